### rtl/core/m3i_pkg.sv
// Shared constants and index tables for the 3x3 matrix inverse block.
`timescale 1ns / 1ps
package m3i_pkg;

  localparam int unsigned NUM_ENT   = 9;
  localparam int unsigned NUM_LANES = 10;
  localparam int unsigned DET_LANE  = 9;

  // Cofactor k is m[a]*m[b] - m[c]*m[d] with {a, b, c, d} = COF_IDX[k].
  localparam int unsigned COF_IDX [NUM_ENT][4] = '{
    '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

  // Cofactors that multiply the first row in the determinant expansion.
  localparam int unsigned DET_COF [3] = '{0, 3, 6};

endpackage

### rtl/core/m3i_front.sv
// Cofactor and determinant front end: five pipeline stages.
`timescale 1ns / 1ps
module m3i_front import m3i_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] m_i   [NUM_ENT],
  output logic signed [2*W:0] cof_o [NUM_ENT],
  output logic signed [3*W+2:0] det_o
);

  localparam int DETW = 3 * W + 3;

  logic signed [W-1:0]    m_q    [NUM_ENT];
  logic signed [2*W-1:0]  p1_q   [NUM_ENT];
  logic signed [2*W-1:0]  p2_q   [NUM_ENT];
  logic signed [W-1:0]    row1_q [3];
  logic signed [W-1:0]    row2_q [3];
  logic signed [2*W:0]    cof2_q [NUM_ENT];
  logic signed [2*W:0]    cof3_q [NUM_ENT];
  logic signed [2*W:0]    cof4_q [NUM_ENT];
  logic signed [2*W:0]    pl_q   [3];
  logic signed [2*W:0]    ph_q   [3];
  logic signed [DETW-1:0] det_d;
  logic signed [DETW-1:0] det_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= m_i;
      for (int j = 0; j < 3; j++) begin
        row1_q[j] <= m_q[j];
        row2_q[j] <= row1_q[j];
      end
      cof3_q <= cof2_q;
      cof4_q <= cof3_q;
      det_q  <= det_d;
    end
  end

  for (genvar k = 0; k < NUM_ENT; k++) begin : g_cof
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p1_q[k]   <= m_q[COF_IDX[k][0]] * m_q[COF_IDX[k][1]];
        p2_q[k]   <= m_q[COF_IDX[k][2]] * m_q[COF_IDX[k][3]];
        cof2_q[k] <= {p1_q[k][2*W-1], p1_q[k]} - {p2_q[k][2*W-1], p2_q[k]};
      end
    end
  end

  // Each first-row product is split into two W by W+1 products.
  for (genvar j = 0; j < 3; j++) begin : g_part
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pl_q[j] <= row2_q[j] * $signed({1'b0, cof2_q[DET_COF[j]][W-1:0]});
        ph_q[j] <= row2_q[j] * $signed(cof2_q[DET_COF[j]][2*W:W]);
      end
    end
  end

  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DETW'(ph_q[j]) <<< W) + DETW'(pl_q[j]);
    end
  end

  assign cof_o = cof4_q;
  assign det_o = det_q;

endmodule

### rtl/core/m3i_lane.sv
// One divider lane: rounded, saturated signed quotient, one bit per stage.
`timescale 1ns / 1ps
module m3i_lane #(
  parameter int W    = 32,
  parameter int NUMW = 99,
  parameter int DENW = 99
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [NUMW-1:0] num_i,
  input  logic signed [DENW-1:0] den_i,
  output logic signed [W-1:0]    q_o
);

  localparam int K  = W + 1;
  localparam int NW = NUMW + 3;
  localparam int XW = NW + K + 1;

  logic [NUMW:0]   absn;
  logic [DENW:0]   absd;
  logic [NW-1:0]   n_pre;
  logic [NW-1:0]   d_pre;
  logic            over_pre;

  logic [NW-1:0]   r_q   [K+1];
  logic [NW-1:0]   d_q   [K+1];
  logic [K-1:0]    q_q   [K+1];
  logic            neg_q [K+1];
  logic            ov_q  [K+1];

  logic [K-1:0]    lim;
  logic [K-1:0]    mag;
  logic [K-1:0]    mag_neg;

  // Rounding half away from zero: quotient of (2|n| + |d|) by 2|d|.
  always_comb begin
    absn  = num_i[NUMW-1] ? ({1'b0, ~num_i} + 1'b1) : {1'b0, num_i};
    absd  = den_i[DENW-1] ? ({1'b0, ~den_i} + 1'b1) : {1'b0, den_i};
    n_pre = (NW'(absn) << 1) + NW'(absd);
    d_pre = NW'(absd) << 1;
    over_pre = XW'(n_pre) >= (XW'(d_pre) << K);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= n_pre;
      d_q[0]   <= d_pre;
      q_q[0]   <= '0;
      neg_q[0] <= num_i[NUMW-1] ^ den_i[DENW-1];
      ov_q[0]  <= over_pre;
    end
  end

  for (genvar j = 1; j <= K; j++) begin : g_step
    logic [XW-1:0] sh;
    logic          ge;
    assign sh = XW'(d_q[j-1]) << (K - j);
    assign ge = XW'(r_q[j-1]) >= sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]   <= ge ? NW'(XW'(r_q[j-1]) - sh) : r_q[j-1];
        q_q[j]   <= q_q[j-1] | (K'(ge) << (K - j));
        d_q[j]   <= d_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ov_q[j]  <= ov_q[j-1];
      end
    end
  end

  always_comb begin
    lim = K'(1) << (W - 1);
    if (neg_q[K]) begin
      mag     = (ov_q[K] || q_q[K] > lim) ? lim : q_q[K];
      mag_neg = ~mag + 1'b1;
      q_o     = mag_neg[W-1:0];
    end else begin
      mag     = (ov_q[K] || q_q[K] > lim - 1'b1) ? lim - 1'b1 : q_q[K];
      mag_neg = '0;
      q_o     = mag[W-1:0];
    end
  end

endmodule

### rtl/core/matrix3_inverse_det_top.sv
// Throughput: one matrix per cycle while the skid register is free; nine divider lanes
// each resolve one quotient bit per stage over DATA_WIDTH + 1 stages after five cofactor
// and determinant stages, while the determinant lane rounds by a shift and is
// delayed to match.
// An output register and a skid register let input continue while a result waits.
// Reset (rst_ni low, asynchronous) empties the pipeline and both output registers.
`timescale 1ns / 1ps
module matrix3_inverse_det_top import m3i_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up.
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22, determinant from the lowest bit up.
  output logic [((10*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // singular.
  output logic m_axis_tuser_o
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int K    = W + 1;
  localparam int DENW = 3 * W + 3;
  localparam int DABW = DENW + 1;
  localparam int NUMW = (2*W + 1 + 2*F > DENW) ? 2*W + 1 + 2*F : DENW;
  localparam int SI   = K + 6;
  localparam int TDO  = ((10*W+7)/8)*8;

  logic                  en;
  logic [SI-1:0]         v_q;
  logic                  z_q [K+1];
  logic signed [W-1:0]   m    [NUM_ENT];
  logic signed [2*W:0]   cof  [NUM_ENT];
  logic signed [DENW-1:0] det;
  logic signed [NUMW-1:0] lane_num [NUM_ENT];
  logic signed [DENW-1:0] lane_den [NUM_ENT];
  logic signed [W-1:0]   lane_q   [NUM_LANES];
  logic [TDO-1:0]        res_data;
  logic [TDO-1:0]        out_q, skid_q;
  logic                  out_sing_q, skid_sing_q;
  logic                  v_o_q, v_s_q;

  for (genvar k = 0; k < NUM_ENT; k++) begin : g_unpack
    assign m[k] = s_axis_tdata_i[k*W +: W];
  end

  // The pipeline runs whenever the skid register is free.
  assign en              = !v_s_q;
  assign s_axis_tready_o = en;

  m3i_front #(.W(W)) u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .m_i   (m),
    .cof_o (cof),
    .det_o (det)
  );

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    if (k == DET_LANE) begin : g_det
      // The determinant scale is a power of two, so its quotient is a rounded
      // right shift, delayed to line up with the divider lanes.
      logic [DABW-1:0]     dabs;
      logic [DABW-1:0]     drnd;
      logic [DABW-1:0]     dlim;
      logic [DABW-1:0]     dmag;
      logic [DABW-1:0]     dres;
      logic signed [W-1:0] dq_q [K+1];

      always_comb begin
        dabs = det[DENW-1] ? ({1'b0, ~det} + 1'b1) : {1'b0, det};
        drnd = (dabs + (DABW'(1) << (2*F-1))) >> (2*F);
        dlim = DABW'(1) << (W-1);
        if (det[DENW-1]) begin
          dmag = (drnd > dlim) ? dlim : drnd;
          dres = ~dmag + 1'b1;
        end else begin
          dmag = (drnd > dlim - 1'b1) ? dlim - 1'b1 : drnd;
          dres = dmag;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          dq_q[0] <= dres[W-1:0];
          for (int j = 1; j <= K; j++) begin
            dq_q[j] <= dq_q[j-1];
          end
        end
      end

      assign lane_q[k] = dq_q[K];
    end else begin : g_inv
      assign lane_num[k] = NUMW'(cof[k]) <<< (2*F);
      assign lane_den[k] = det;
      m3i_lane #(.W(W), .NUMW(NUMW), .DENW(DENW)) u_lane (
        .clk_i (clk_i),
        .en_i  (en),
        .num_i (lane_num[k]),
        .den_i (lane_den[k]),
        .q_o   (lane_q[k])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      z_q[0] <= (det == '0);
      for (int j = 1; j <= K; j++) begin
        z_q[j] <= z_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[SI-2:0], s_axis_tvalid_i};
    end
  end

  // Merge the lanes; a singular matrix forces every field to zero.
  always_comb begin
    res_data = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      res_data[k*W +: W] = z_q[K] ? '0 : lane_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_o_q <= 1'b0;
      v_s_q <= 1'b0;
    end else if (!v_o_q || m_axis_tready_i) begin
      if (v_s_q) begin
        v_o_q <= 1'b1;
        v_s_q <= 1'b0;
      end else begin
        v_o_q <= v_q[SI-1];
      end
    end else if (en && v_q[SI-1]) begin
      v_s_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!v_o_q || m_axis_tready_i) begin
      if (v_s_q) begin
        out_q      <= skid_q;
        out_sing_q <= skid_sing_q;
      end else begin
        out_q      <= res_data;
        out_sing_q <= z_q[K];
      end
    end else if (en) begin
      skid_q      <= res_data;
      skid_sing_q <= z_q[K];
    end
  end

  assign m_axis_tvalid_o = v_o_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tuser_o  = out_sing_q;

endmodule

### rtl/core/m3i_chk.sv
// Port-level checker for the matrix inverse block and its bind.
`timescale 1ns / 1ps
module m3i_chk #(
  parameter int DATA_WIDTH = 32
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready_o,
  input logic m_axis_tvalid_o,
  input logic m_axis_tready_i,
  input logic [((10*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  input logic m_axis_tuser_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output transfer changed");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("singular result carries nonzero fields");

  a_stall_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o && $past(s_axis_tready_o) |->
      $past(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without an output stall");

endmodule

bind matrix3_inverse_det_top m3i_chk #(.DATA_WIDTH(DATA_WIDTH)) u_m3i_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
